>>> design/stsched_pkg.sv
// Shared types and constants of the stride scheduler table.
// Holds the request and status codes and the layout of one table entry.
// Has no dependencies.
package stsched_pkg;

  localparam logic [2:0] REQ_SPAWN   = 3'd0;
  localparam logic [2:0] REQ_SETTIX  = 3'd1;
  localparam logic [2:0] REQ_SETRUN  = 3'd2;
  localparam logic [2:0] REQ_SCHED   = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ZERO_TIX = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [30:0] PASS_MAX   = 31'h7ffffffe;
  localparam logic [31:0] TICKS_MAX  = 32'hffffffff;
  localparam logic [15:0] STRIDE_BASE_RESET = 16'd10000;

  // One table entry as it is stored in the entry memory.
  typedef struct packed {
    logic        runnable;
    logic [15:0] tickets;
    logic [15:0] stride;
    logic [30:0] pass;
    logic [31:0] ticks;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SCHED = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

endpackage

>>> design/stride_scheduler_table_core.sv
// Stride scheduler over a table of task entries kept in one entry memory.
// Spawn, read and set runnable pass through the look-up, modify and emit states; set tickets
// adds a 16-step serial divider before modify; schedule sweeps the N allocated entries instead.
// One request is in flight at a time; the next beat is taken once the result is registered.
// Reset is synchronous: after reset the table reads as empty and stride_base is 10000.
// There is no clearing pass: the allocation count marks which entries are live.
module stride_scheduler_table_core #(
  parameter int unsigned NUM_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  // entry_index[5:0], has_parent[6], parent_index[12:7], ticket_count[28:13],
  // runnable_flag[29], zero[31:30]
  input  logic [31:0]  s_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // result_index[5:0], entry_in_use[6], entry_tickets[22:7], entry_stride[38:23],
  // entry_pass[69:39], entry_ticks[101:70], zero[103:102]
  output logic [103:0] m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import stsched_pkg::*;

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  state_t        state;
  logic [CW-1:0] next_free;
  logic [15:0]   stride_base;

  logic [2:0]    req;
  logic [5:0]    idx;
  logic          has_par;
  logic [5:0]    par;
  logic [15:0]   cnt;
  logic          flag;

  entry_t        mem [NUM_ENTRIES];
  entry_t        rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  logic [15:0]   div_rem;
  logic [15:0]   div_q;
  logic [3:0]    div_cnt;
  logic [16:0]   div_trial;

  logic [CW-1:0] scan_cnt;
  logic          scan_more;
  logic          pv;
  logic [AW-1:0] pidx;
  logic          found;
  logic [AW-1:0] best_idx;
  entry_t        best;

  logic          accept;
  logic          idx_ok;
  logic          idx_used;
  logic          par_used;
  logic          full;

  logic [1:0]    mod_status;
  logic [5:0]    mod_idx;
  entry_t        rep_src;
  logic          rep_show;
  logic          rep_used;
  entry_t        rep_out;
  entry_t        new_e;
  logic [31:0]   psum;

  logic [1:0]    res_status;
  logic [5:0]    res_idx;
  logic          res_in_use;
  entry_t        res_e;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign idx_ok   = 32'(idx) < 32'(NUM_ENTRIES);
  assign idx_used = 32'(idx) < 32'(next_free);
  assign par_used = 32'(par) < 32'(next_free);
  assign full     = 32'(next_free) >= 32'(NUM_ENTRIES);
  assign scan_more = (state == S_SCAN) && (scan_cnt < next_free);

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = {16'd0, stride_base};
    end
  end

  // Read address: the request's own entry at accept (the parent entry for a spawn), the sweep counter during a scan.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(s_tdata[5:0]);
    if (accept) begin
      rd_en = 1'b1;
      if (s_tuser == REQ_SPAWN) begin
        rd_addr = AW'(s_tdata[12:7]);
      end
    end else if (scan_more) begin
      rd_en   = 1'b1;
      rd_addr = AW'(scan_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign div_trial = {div_rem, div_q[15]};
  assign psum      = 32'(best.pass) + 32'(best.stride);

  // Write-back and result of the modify and schedule steps.
  always_comb begin
    we         = 1'b0;
    waddr      = AW'(idx);
    wdata      = rdata;
    new_e      = rdata;
    mod_status = ST_OK;
    mod_idx    = idx;
    rep_src    = rdata;
    rep_show   = idx_ok;
    rep_used   = idx_used;
    if (state == S_SCHED) begin
      if (!found) begin
        mod_status = ST_NONE;
        mod_idx    = '0;
        rep_show   = 1'b0;
      end else begin
        new_e = best;
        if (best.ticks != TICKS_MAX) begin
          new_e.ticks = best.ticks + 32'd1;
        end
        new_e.pass = (psum > 32'(PASS_MAX)) ? PASS_MAX : psum[30:0];
        we       = 1'b1;
        waddr    = best_idx;
        wdata    = new_e;
        mod_idx  = 6'(best_idx);
        rep_src  = new_e;
        rep_show = 1'b1;
        rep_used = 1'b1;
      end
    end else if (state == S_MOD) begin
      unique case (req)
        REQ_SPAWN: begin
          if (full) begin
            mod_status = ST_FULL;
            mod_idx    = '0;
            rep_show   = 1'b0;
          end else begin
            new_e.runnable = 1'b1;
            new_e.ticks    = '0;
            if (!(has_par && par_used)) begin
              new_e.tickets = 16'd1;
              new_e.stride  = stride_base;
            end
            new_e.pass = 31'(new_e.stride);
            we       = 1'b1;
            waddr    = AW'(next_free);
            wdata    = new_e;
            mod_idx  = 6'(next_free);
            rep_src  = new_e;
            rep_show = 1'b1;
            rep_used = 1'b1;
          end
        end
        REQ_SETTIX: begin
          if (cnt == 16'd0) begin
            mod_status = ST_ZERO_TIX;
          end else if (idx_ok && idx_used) begin
            new_e.tickets = cnt;
            new_e.stride  = div_q;
            if (rdata.ticks == 32'd0) begin
              new_e.pass = 31'(div_q);
            end
            we      = 1'b1;
            wdata   = new_e;
            rep_src = new_e;
          end
        end
        REQ_SETRUN: begin
          if (idx_ok) begin
            new_e.runnable = flag;
            we    = 1'b1;
            wdata = new_e;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry fields as the result beat shows them: nothing for a hidden entry, and an
  // entry that was never allocated has not been scheduled yet.
  always_comb begin
    rep_out = rep_src;
    if (!rep_show) begin
      rep_out = '0;
    end else if (!rep_used) begin
      rep_out.ticks = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      next_free   <= '0;
      stride_base <= STRIDE_BASE_RESET;
      m_tvalid    <= 1'b0;
      pv          <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && !paddr[2]) begin
        stride_base <= pwdata[15:0];
      end
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req      <= s_tuser;
            idx      <= s_tdata[5:0];
            has_par  <= s_tdata[6];
            par      <= s_tdata[12:7];
            cnt      <= s_tdata[28:13];
            flag     <= s_tdata[29];
            scan_cnt <= '0;
            pv       <= 1'b0;
            found    <= 1'b0;
            state    <= (s_tuser == REQ_SCHED) ? S_SCAN : S_LOOK;
          end
        end
        S_LOOK: begin
          if (req == REQ_SETTIX && idx_ok && idx_used && cnt != 16'd0) begin
            div_rem <= '0;
            div_q   <= stride_base;
            div_cnt <= 4'd15;
            state   <= S_DIV;
          end else begin
            state <= S_MOD;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (div_trial >= {1'b0, cnt}) begin
            div_rem <= 16'(div_trial - {1'b0, cnt});
            div_q   <= {div_q[14:0], 1'b1};
          end else begin
            div_rem <= div_trial[15:0];
            div_q   <= {div_q[14:0], 1'b0};
          end
          div_cnt <= div_cnt - 4'd1;
          if (div_cnt == 4'd0) begin
            state <= S_MOD;
          end
        end
        S_SCAN: begin
          // Read data is registered, so it arrives in the cycle after its address; pv marks a valid sample.
          if (scan_more) begin
            scan_cnt <= scan_cnt + CW'(1);
            pidx     <= AW'(scan_cnt);
            pv       <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv && rdata.runnable && (!found || rdata.pass < best.pass)) begin
            found    <= 1'b1;
            best     <= rdata;
            best_idx <= pidx;
          end
          if (!scan_more && !pv) begin
            state <= S_SCHED;
          end
        end
        S_MOD, S_SCHED: begin
          res_status <= mod_status;
          res_idx    <= mod_idx;
          res_in_use <= rep_show && rep_used;
          res_e      <= rep_out;
          if (state == S_MOD && req == REQ_SPAWN && !full) begin
            next_free <= next_free + CW'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, res_e.ticks, res_e.pass, res_e.stride, res_e.tickets,
                         res_in_use, res_idx};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_free) <= 32'(NUM_ENTRIES))
    else $error("allocation count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    ##1 ((next_free == $past(next_free)) || (next_free == CW'($past(next_free) + CW'(1)))))
    else $error("allocation count moved by more than one");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 4'd0) |=> (state == S_MOD))
    else $error("divider did not hand over to the modify step");

  a_best_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHED && found) |-> (32'(best_idx) < 32'(next_free)))
    else $error("scheduled entry is not allocated");
`endif

endmodule
